/* src/gji_pkg.sv */
// Shared types, constants and Q16.16 arithmetic helpers for the matrix inverter.
package gji_pkg;

    localparam int DATA_W    = 32;
    localparam int CFG_W     = 4;
    localparam int DIV_STEPS = 34;

    localparam logic signed [DATA_W-1:0] Q_ONE = 32'sh0001_0000;
    localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

    typedef enum logic [4:0] {
        S_IDLE,
        S_PV_RD,
        S_PV_CMP,
        S_DIV,
        S_RCP,
        S_SC_RB,
        S_SC_RJ,
        S_SC_CAP,
        S_SC_WJ,
        S_EL_ROW,
        S_EL_F,
        S_EL_RJ,
        S_EL_RI,
        S_EL_WR,
        S_OUT_RD,
        S_OUT_WR,
        S_SING
    } t_state;

    function automatic logic [DATA_W-1:0] f_mag32(input logic signed [DATA_W-1:0] v);
        return v[DATA_W-1] ? DATA_W'(-v) : DATA_W'(v);
    endfunction

    function automatic logic signed [DATA_W-1:0] f_from_mag(input logic neg,
                                                             input logic [63:0] m);
        logic signed [DATA_W-1:0] res;
        if (neg) begin
            if (m >= 64'h8000_0000) res = Q_MIN;
            else res = -$signed(m[DATA_W-1:0]);
        end else begin
            if (m > 64'h7FFF_FFFF) res = Q_MAX;
            else res = $signed(m[DATA_W-1:0]);
        end
        return res;
    endfunction

    function automatic logic signed [DATA_W-1:0] f_qmul(input logic signed [63:0] p);
        logic [63:0] mag;
        logic [63:0] m;
        mag = p[63] ? 64'(-p) : 64'(p);
        m   = (mag + 64'h8000) >> 16;
        return f_from_mag(p[63], m);
    endfunction

    function automatic logic signed [DATA_W-1:0] f_sat_add(input logic signed [DATA_W-1:0] a,
                                                            input logic signed [DATA_W-1:0] b);
        logic signed [DATA_W:0] s;
        logic signed [DATA_W-1:0] res;
        s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        if (s[DATA_W] != s[DATA_W-1]) res = s[DATA_W] ? Q_MIN : Q_MAX;
        else res = s[DATA_W-1:0];
        return res;
    endfunction

    function automatic logic signed [DATA_W-1:0] f_qneg(input logic signed [DATA_W-1:0] a);
        return (a == Q_MIN) ? Q_MAX : -a;
    endfunction

endpackage

/* src/gji_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module gji_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/gauss_jordan_matrix_inverse.sv */
// Top level of the Q16.16 Gauss-Jordan matrix inverter with partial pivoting.
// The matrix is loaded one element per cycle in row-major order while busy is low; the last
// element starts the inversion and raises busy. The work copy and the inverse live in two
// RAMs sharing one address sequencer and a one-read, one-write port each; every element
// access waits for a registered read. Per column j the run does a pivot search, a bit-serial
// reciprocal of the pivot, the scale and swap of the pivot row and the elimination of each
// other row; the inverse is then read out in row-major order. Results appear one cycle wide
// on o_valid and cannot be stalled; a singular matrix gives a single result with o_singular
// and o_last set.
module gauss_jordan_matrix_inverse #(
    parameter int MAX_DIM = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [gji_pkg::CFG_W-1:0]            i_cfg_wdata,
    input  logic                                 i_start,
    output logic                                 o_busy,
    input  logic signed [gji_pkg::DATA_W-1:0]    i_element,
    output logic                                 o_valid,
    output logic signed [gji_pkg::DATA_W-1:0]    o_value,
    output logic                                 o_singular,
    output logic                                 o_last
);

    import gji_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int DW    = $clog2(MAX_DIM + 1);

    function automatic logic [AW-1:0] f_addr(input logic [DW-1:0] r, input logic [DW-1:0] c);
        return AW'(int'(r) * MAX_DIM + int'(c));
    endfunction

    t_state r_state, n_state;

    logic [CFG_W-1:0]         r_size;
    logic [DW-1:0]            w_n, w_nm1;
    logic [DW-1:0]            r_lr, r_lc, r_j, r_i, r_c, r_best;
    logic [DATA_W-1:0]        r_bmag;
    logic signed [DATA_W-1:0] r_piv, r_rcp, r_nf;
    logic [DIV_STEPS-1:0]     r_dnum;
    logic [DATA_W-1:0]        r_dm, r_rem;
    logic                     r_dneg;
    logic [5:0]               r_dcnt;
    logic signed [63:0]       r_pw, r_pi;
    logic                     r_valid, r_singular, r_last;
    logic signed [DATA_W-1:0] r_value;

    logic                     w_we;
    logic [AW-1:0]            w_waddr, w_raddr;
    logic [DATA_W-1:0]        w_wd_w, w_wd_i, w_rd_w, w_rd_i;
    logic [DATA_W-1:0]        w_mag;
    logic                     w_upd;
    logic [DATA_W-1:0]        w_bmag;
    logic signed [DATA_W-1:0] w_bval;
    logic [DATA_W:0]          w_rem_sh;
    logic                     w_qbit;

    always_comb begin
        if (r_size == '0) w_n = DW'(1);
        else if (int'(r_size) > MAX_DIM) w_n = DW'(MAX_DIM);
        else w_n = DW'(r_size);
        w_nm1 = w_n - 1'b1;
    end

    assign w_mag    = f_mag32($signed(w_rd_w));
    assign w_upd    = (r_i == r_j) || (w_mag > r_bmag);
    assign w_bmag   = w_upd ? w_mag : r_bmag;
    assign w_bval   = w_upd ? $signed(w_rd_w) : r_piv;
    assign w_rem_sh = {r_rem, r_dnum[DIV_STEPS-1]};
    assign w_qbit   = (w_rem_sh >= {1'b0, r_dm});

    gji_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_work_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wd_w),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_w)
    );

    gji_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_inv_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wd_i),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_i)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        w_we    = 1'b0;
        w_waddr = f_addr(r_j, r_c);
        w_raddr = f_addr(r_j, r_c);
        w_wd_w  = '0;
        w_wd_i  = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    w_we    = 1'b1;
                    w_waddr = f_addr(r_lr, r_lc);
                    w_wd_w  = i_element;
                    w_wd_i  = (r_lr == r_lc) ? Q_ONE : '0;
                    if (r_lr == w_nm1 && r_lc == w_nm1) n_state = S_PV_RD;
                end
            end
            S_PV_RD: begin
                w_raddr = f_addr(r_i, r_j);
                n_state = S_PV_CMP;
            end
            S_PV_CMP: begin
                if (r_i == w_nm1) n_state = (w_bmag == '0) ? S_SING : S_DIV;
                else n_state = S_PV_RD;
            end
            S_DIV: begin
                if (r_dcnt == '0) n_state = S_RCP;
            end
            S_RCP: begin
                n_state = S_SC_RB;
            end
            S_SC_RB: begin
                w_raddr = f_addr(r_best, r_c);
                n_state = S_SC_RJ;
            end
            S_SC_RJ: begin
                w_raddr = f_addr(r_j, r_c);
                n_state = S_SC_CAP;
            end
            S_SC_CAP: begin
                w_we    = 1'b1;
                w_waddr = f_addr(r_best, r_c);
                w_wd_w  = w_rd_w;
                w_wd_i  = w_rd_i;
                n_state = S_SC_WJ;
            end
            S_SC_WJ: begin
                w_we    = 1'b1;
                w_waddr = f_addr(r_j, r_c);
                w_wd_w  = (r_c == r_j) ? Q_ONE : f_qmul(r_pw);
                w_wd_i  = f_qmul(r_pi);
                n_state = (r_c == w_nm1) ? S_EL_ROW : S_SC_RB;
            end
            S_EL_ROW: begin
                w_raddr = f_addr(r_i, r_j);
                if (r_i == w_n) n_state = (r_j == w_nm1) ? S_OUT_RD : S_PV_RD;
                else if (r_i != r_j) n_state = S_EL_F;
            end
            S_EL_F: begin
                n_state = S_EL_RJ;
            end
            S_EL_RJ: begin
                w_raddr = f_addr(r_j, r_c);
                n_state = S_EL_RI;
            end
            S_EL_RI: begin
                w_raddr = f_addr(r_i, r_c);
                n_state = S_EL_WR;
            end
            S_EL_WR: begin
                w_we    = 1'b1;
                w_waddr = f_addr(r_i, r_c);
                w_wd_w  = (r_c == r_j) ? '0 : f_sat_add($signed(w_rd_w), f_qmul(r_pw));
                w_wd_i  = f_sat_add($signed(w_rd_i), f_qmul(r_pi));
                n_state = (r_c == w_nm1) ? S_EL_ROW : S_EL_RJ;
            end
            S_OUT_RD: begin
                w_raddr = f_addr(r_i, r_c);
                n_state = S_OUT_WR;
            end
            S_OUT_WR: begin
                n_state = (r_i == w_nm1 && r_c == w_nm1) ? S_IDLE : S_OUT_RD;
            end
            S_SING: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size     <= CFG_W'(8);
            r_lr       <= '0;
            r_lc       <= '0;
            r_valid    <= 1'b0;
            r_singular <= 1'b0;
            r_last     <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            if (i_cfg_we) begin
                r_size <= i_cfg_wdata;
                r_lr   <= '0;
                r_lc   <= '0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_start && !i_cfg_we) begin
                        if (r_lc == w_nm1) begin
                            r_lc <= '0;
                            r_lr <= (r_lr == w_nm1) ? '0 : r_lr + 1'b1;
                        end else begin
                            r_lc <= r_lc + 1'b1;
                        end
                        r_j <= '0;
                        r_i <= '0;
                    end
                end
                S_PV_CMP: begin
                    r_bmag <= w_bmag;
                    r_piv  <= w_bval;
                    if (w_upd) r_best <= r_i;
                    r_i    <= r_i + 1'b1;
                    r_dm   <= f_mag32(w_bval);
                    r_dneg <= w_bval[DATA_W-1];
                    r_dnum <= DIV_STEPS'(64'h1_0000_0000 + 64'(f_mag32(w_bval) >> 1));
                    r_rem  <= '0;
                    r_dcnt <= 6'(DIV_STEPS - 1);
                end
                S_DIV: begin
                    r_rem  <= w_qbit ? DATA_W'(w_rem_sh - {1'b0, r_dm}) : DATA_W'(w_rem_sh);
                    r_dnum <= {r_dnum[DIV_STEPS-2:0], w_qbit};
                    r_dcnt <= r_dcnt - 1'b1;
                end
                S_RCP: begin
                    r_rcp <= f_from_mag(r_dneg, 64'(r_dnum));
                    r_c   <= '0;
                end
                S_SC_RJ: begin
                    r_pw <= $signed(w_rd_w) * r_rcp;
                    r_pi <= $signed(w_rd_i) * r_rcp;
                end
                S_SC_WJ: begin
                    if (r_c == w_nm1) r_i <= '0;
                    else r_c <= r_c + 1'b1;
                end
                S_EL_ROW: begin
                    if (r_i == w_n) begin
                        r_i <= '0;
                        r_c <= '0;
                        if (r_j != w_nm1) begin
                            r_j <= r_j + 1'b1;
                            r_i <= r_j + 1'b1;
                        end
                    end else if (r_i == r_j) begin
                        r_i <= r_i + 1'b1;
                    end
                end
                S_EL_F: begin
                    r_nf <= f_qneg($signed(w_rd_w));
                    r_c  <= '0;
                end
                S_EL_RI: begin
                    r_pw <= $signed(w_rd_w) * r_nf;
                    r_pi <= $signed(w_rd_i) * r_nf;
                end
                S_EL_WR: begin
                    if (r_c == w_nm1) r_i <= r_i + 1'b1;
                    else r_c <= r_c + 1'b1;
                end
                S_OUT_WR: begin
                    r_valid    <= 1'b1;
                    r_value    <= $signed(w_rd_i);
                    r_singular <= 1'b0;
                    r_last     <= (r_i == w_nm1 && r_c == w_nm1);
                    if (r_c == w_nm1) begin
                        r_c <= '0;
                        r_i <= r_i + 1'b1;
                    end else begin
                        r_c <= r_c + 1'b1;
                    end
                end
                S_SING: begin
                    r_valid    <= 1'b1;
                    r_value    <= '0;
                    r_singular <= 1'b1;
                    r_last     <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_busy     = (r_state != S_IDLE);
    assign o_valid    = r_valid;
    assign o_value    = r_value;
    assign o_singular = r_singular;
    assign o_last     = r_last;

    a_sing_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_singular |-> o_last)
        else $error("singular result without last");

    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> ($past(r_state) == S_OUT_WR || $past(r_state) == S_SING))
        else $error("result strobe outside the output phase");

    a_waddr_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (int'(w_waddr) < DEPTH))
        else $error("RAM write address out of range");

    a_div_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |=> (r_state == S_DIV || r_state == S_RCP))
        else $error("divider left early");

endmodule

/* dv/gji_checker.sv */
// Checker that predicts the matrix inverse of each loaded matrix and compares every result.
`timescale 1ns / 1ps

module gji_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [gji_pkg::CFG_W-1:0]          i_cfg_wdata,
    input  logic                               i_start,
    input  logic                               i_busy,
    input  logic signed [gji_pkg::DATA_W-1:0]  i_element,
    input  logic                               i_valid,
    input  logic signed [gji_pkg::DATA_W-1:0]  i_value,
    input  logic                               i_singular,
    input  logic                               i_last,
    output int                                 o_fail_count,
    output int                                 o_pending
);
    import gji_pkg::*;

    localparam int MAXN = 8;

    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic                     singular;
        logic                     last;
    } t_inv_elem;

    t_inv_elem inverse_q[$];
    int        work_mat [MAXN*MAXN];
    int        inv_mat  [MAXN*MAXN];
    int        loaded;
    logic [CFG_W-1:0] size_reg;

    function automatic int sat_mag(input bit neg, input longint unsigned m);
        if (neg) return (m >= 64'h8000_0000) ? 32'h8000_0000 : -int'(m);
        return (m > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : int'(m);
    endfunction

    function automatic int sat_sum(input longint v);
        if (v > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
        if (v < -64'sh8000_0000) return 32'h8000_0000;
        return int'(v);
    endfunction

    function automatic longint unsigned abs64(input longint v);
        return (v < 0) ? longint'(-v) : v;
    endfunction

    function automatic int fx_mul(input int a, input int b);
        longint p;
        p = longint'(a) * longint'(b);
        return sat_mag(p < 0, (abs64(p) + 64'h8000) >> 16);
    endfunction

    function automatic int fx_recip(input int p);
        longint unsigned m;
        m = abs64(longint'(p));
        if (m == 0) return 0;
        return sat_mag(p < 0, (64'h1_0000_0000 + (m >> 1)) / m);
    endfunction

    function automatic int active_dim();
        if (size_reg == 0) return 1;
        if (size_reg > MAXN) return MAXN;
        return int'(size_reg);
    endfunction

    function automatic void clear_inverse();
        for (int i = 0; i < MAXN*MAXN; i++) inv_mat[i] = 0;
        for (int i = 0; i < MAXN; i++) inv_mat[i*MAXN+i] = 32'h0001_0000;
    endfunction

    function automatic bit eliminate(input int n);
        int best;
        int rcp;
        int nf;
        int t;
        longint unsigned bmag;
        longint unsigned m;
        for (int j = 0; j < n; j++) begin
            best = j;
            bmag = abs64(longint'(work_mat[j*MAXN+j]));
            for (int i = j + 1; i < n; i++) begin
                m = abs64(longint'(work_mat[i*MAXN+j]));
                if (m > bmag) begin
                    bmag = m;
                    best = i;
                end
            end
            if (bmag == 0) return 0;
            rcp = fx_recip(work_mat[best*MAXN+j]);
            for (int c = 0; c < n; c++) begin
                inv_mat[best*MAXN+c]  = fx_mul(inv_mat[best*MAXN+c], rcp);
                work_mat[best*MAXN+c] = fx_mul(work_mat[best*MAXN+c], rcp);
            end
            work_mat[best*MAXN+j] = 32'h0001_0000;
            if (best != j) begin
                for (int c = 0; c < n; c++) begin
                    t = inv_mat[best*MAXN+c];
                    inv_mat[best*MAXN+c] = inv_mat[j*MAXN+c];
                    inv_mat[j*MAXN+c] = t;
                    t = work_mat[best*MAXN+c];
                    work_mat[best*MAXN+c] = work_mat[j*MAXN+c];
                    work_mat[j*MAXN+c] = t;
                end
            end
            for (int i = 0; i < n; i++) begin
                if (i != j) begin
                    nf = sat_sum(-longint'(work_mat[i*MAXN+j]));
                    for (int c = 0; c < n; c++) begin
                        inv_mat[i*MAXN+c] = sat_sum(longint'(inv_mat[i*MAXN+c])
                            + longint'(fx_mul(inv_mat[j*MAXN+c], nf)));
                        work_mat[i*MAXN+c] = sat_sum(longint'(work_mat[i*MAXN+c])
                            + longint'(fx_mul(work_mat[j*MAXN+c], nf)));
                    end
                    work_mat[i*MAXN+j] = 0;
                end
            end
        end
        return 1;
    endfunction

    function automatic void load_element(input int v);
        int n;
        t_inv_elem e;
        n = active_dim();
        if (loaded == 0) clear_inverse();
        if (loaded >= n*n) loaded = 0;
        work_mat[(loaded / n)*MAXN + (loaded % n)] = v;
        loaded++;
        if (loaded < n*n) return;
        loaded = 0;
        if (!eliminate(n)) begin
            e.value = 0;
            e.singular = 1;
            e.last = 1;
            inverse_q.push_back(e);
            return;
        end
        for (int k = 0; k < n*n; k++) begin
            e.value = inv_mat[(k / n)*MAXN + (k % n)];
            e.singular = 0;
            e.last = (k + 1 == n*n);
            inverse_q.push_back(e);
        end
    endfunction

    assign o_pending = inverse_q.size();

    initial o_fail_count = 0;

    always @(posedge i_clk) begin
        t_inv_elem want;
        int errs;
        errs = 0;
        if (!i_rst_n) begin
            for (int i = 0; i < MAXN*MAXN; i++) work_mat[i] = 0;
            clear_inverse();
            loaded = 0;
            size_reg = 8;
            inverse_q.delete();
        end else begin
            if (i_valid) begin
                if (inverse_q.size() == 0) begin
                    $error("unexpected result value=%0d singular=%0b last=%0b",
                           i_value, i_singular, i_last);
                    errs++;
                end else begin
                    want = inverse_q.pop_front();
                    if (i_value !== want.value) begin
                        $error("value: expected %0d, got %0d", want.value, i_value);
                        errs++;
                    end
                    if (i_singular !== want.singular) begin
                        $error("singular: expected %0b, got %0b", want.singular, i_singular);
                        errs++;
                    end
                    if (i_last !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, i_last);
                        errs++;
                    end
                end
            end
            if (errs != 0) o_fail_count <= o_fail_count + errs;
            if (i_cfg_we) begin
                size_reg = i_cfg_wdata;
                loaded = 0;
            end
            if (i_start && !i_busy) load_element(i_element);
        end
    end

endmodule

/* dv/testbench.sv */
// Top of the matrix inverter testbench: clock, reset, request stimulus and the verdict.
`timescale 1ns / 1ps

module testbench;
    import gji_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int ITEM_TARGET = 260;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [CFG_W-1:0]   i_cfg_wdata;
    logic               i_start;
    logic               o_busy;
    logic signed [DATA_W-1:0] i_element;
    logic               o_valid;
    logic signed [DATA_W-1:0] o_value;
    logic               o_singular;
    logic               o_last;
    int                 fail_count;
    int                 pending;
    int                 cycles;
    int                 requests;
    int                 matrices;
    bit                 calm;

    gauss_jordan_matrix_inverse dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_start(i_start), .o_busy(o_busy), .i_element(i_element), .o_valid(o_valid),
        .o_value(o_value), .o_singular(o_singular), .o_last(o_last)
    );

    gji_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_start(i_start), .i_busy(o_busy), .i_element(i_element), .i_valid(o_valid),
        .i_value(o_value), .i_singular(o_singular), .i_last(o_last),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    task automatic send_request(input logic [DATA_W-1:0] v);
        if (!calm && $urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 6)) begin
                @(negedge i_clk);
                i_start <= 1'b0;
            end
        end
        forever begin
            @(negedge i_clk);
            if (!o_busy) begin
                i_start <= 1'b1;
                i_element <= v;
                requests++;
                break;
            end
            i_start <= 1'b0;
        end
    endtask

    task automatic settle();
        @(negedge i_clk);
        i_start <= 1'b0;
        while (pending != 0 || o_busy) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    task automatic write_size(input logic [CFG_W-1:0] v);
        settle();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [DATA_W-1:0] pick_element(input int kind, input int n,
                                                       input int r, input int c);
        logic [DATA_W-1:0] v;
        case (kind)
            0, 1, 2, 3, 4, 5: begin
                if (r == c) begin
                    v = n * 32'h0002_0000 + $urandom_range(0, 32'h0004_0000);
                    if ($urandom_range(0, 1)) v = -v;
                end else begin
                    v = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
                end
            end
            6: v = $urandom;
            7: v = (r == n - 1) ? 32'h0 : $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
            default: v = ($urandom_range(0, 8) - 4) <<< 16;
        endcase
        return v;
    endfunction

    initial begin
        int n;
        int kind;
        int cut;
        int sz;
        cycles = 0;
        requests = 0;
        matrices = 0;
        calm = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        i_start = 1'b0;
        i_element = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_size(4'd0);
        send_request(32'h0000_0000);
        send_request(32'h8000_0000);
        send_request(32'h0000_0001);
        send_request(32'h7FFF_FFFF);
        write_size(4'd2);
        send_request(32'h0000_0000);
        send_request(32'h0001_0000);
        send_request(32'h0002_0000);
        send_request(32'h0000_0000);
        send_request(32'h0001_0000);
        send_request(32'h0002_0000);
        send_request(32'h0002_0000);
        send_request(32'h0004_0000);
        send_request(32'hFFFF_0000);
        send_request(32'h0003_0000);
        write_size(4'd3);
        for (int i = 0; i < 9; i++) send_request((i % 4 == 0) ? 32'h0002_0000 : 32'h0000_4000);
        matrices = 7;

        for (int ph = 0; requests < ITEM_TARGET; ph++) begin
            if (ph == 0) sz = 15;
            else if (ph == 1) sz = 8;
            else begin
                case ($urandom_range(0, 11))
                    0: sz = 0;
                    1, 2: sz = 1;
                    3, 4, 5: sz = 2;
                    6, 7: sz = 3;
                    8: sz = 4;
                    9: sz = $urandom_range(5, 7);
                    10: sz = 8;
                    default: sz = $urandom_range(9, 15);
                endcase
            end
            calm = (requests > ITEM_TARGET - 40);
            write_size(sz[CFG_W-1:0]);
            n = (sz == 0) ? 1 : (sz > 8 ? 8 : sz);
            kind = $urandom_range(0, 9);
            cut = (kind == 9 && n > 1) ? $urandom_range(1, n*n - 1) : n*n;
            for (int k = 0; k < cut; k++) send_request(pick_element(kind, n, k / n, k % n));
            if (cut == n*n) matrices++;
        end

        settle();
        $display("Sent %0d element requests forming %0d complete matrices,", requests, matrices);
        $display("with sizes from 1 to 8, singular and saturating cases included.");
        if (fail_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
